/* sv/ipsp_pkg.sv */
// ----------------------------------------------------------------------------
// ipsp_pkg
// Shared types and constants for the throttled IP-stride prefetcher.
// ----------------------------------------------------------------------------
package ipsp_pkg;

    localparam int STRIDE_W = 59;
    localparam int LINE_W   = 58;
    localparam int CNT_W    = 32;
    localparam int DEG_W    = 11;
    localparam int MSHR_W   = 9;

    localparam logic [0:0] FUNC_ACCESS = 1'b0;
    localparam logic [0:0] FUNC_TICK   = 1'b1;

    localparam logic [0:0] REG_VIRT = 1'b0;
    localparam logic [0:0] REG_MSHR = 1'b1;

    // One tracker entry.
    typedef struct packed {
        logic [63:0]         ip;
        logic [LINE_W-1:0]   line;
        logic [STRIDE_W-1:0] stride;
        logic [63:0]         stamp;
    } trk_entry_t;

endpackage

/* sv/ipsp_tracker.sv */
// ----------------------------------------------------------------------------
// ipsp_tracker
// Tracker memory with a clearing sweep after reset. One read port, one write
// port, registered read data.
// ----------------------------------------------------------------------------
module ipsp_tracker
    import ipsp_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output trk_entry_t               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  trk_entry_t               wr_data,
    output logic                     clr_done
);
    localparam int AW = $clog2(DEPTH);

    trk_entry_t mem [DEPTH];
    logic [AW:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clr_cnt_reg != (AW+1)'(DEPTH)) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign clr_done = (clr_cnt_reg == (AW+1)'(DEPTH));

    always_ff @(posedge aclk) begin
        if (!clr_done) begin
            mem[clr_cnt_reg[AW-1:0]] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* sv/ip_stride_prefetcher_throttled.sv */
// ----------------------------------------------------------------------------
// ip_stride_prefetcher_throttled
// IP-indexed stride tracker with a lookahead prefetch and degree throttling.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one transaction per event: func in tuser (0 access,
//   1 tick), other fields in tdata. Every transaction yields exactly one
//   result transaction on the m_ channel.
//   An access reads the WAYS entries of its set one per cycle through the
//   single tracker read port, picks a way and writes it back, then passes
//   through ST_OUT to m_tvalid. A tick runs the two degree compares on
//   one shared compare unit over two steps, then the update and address
//   step, then ST_OUT.
//   s_tready is low while an item is in flight and while the result waits
//   in the output register; a stalled receiver holds the block. s_tready
//   returns the cycle after the result is taken.
//   After reset the tracker memory is swept to zero, one entry per cycle,
//   before the first transaction is taken. Configuration writes must be
//   made over the APB port while no transaction is in flight (unchecked).
// ----------------------------------------------------------------------------
module ip_stride_prefetcher_throttled
    import ipsp_pkg::*;
#(
    parameter int SETS      = 256,
    parameter int WAYS      = 4,
    parameter int LINE_BITS = 6,
    parameter int PAGE_BITS = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: access_addr[63:0], instr_ptr[127:64], was_hit[128],
    // mshr_occupancy[137:129], prefetch_accepted[138], zero pad
    input  logic [143:0] s_tdata,
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: pf_valid[0], pf_addr[64:1], fill_this_level[65],
    // current_degree[76:66], zero pad
    output logic [79:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int DEPTH = SETS * WAYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CAP   = (DEPTH > 1024) ? 1024 : DEPTH;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_WR   = 3'd2;
    localparam logic [2:0] ST_T0   = 3'd3;
    localparam logic [2:0] ST_T1   = 3'd4;
    localparam logic [2:0] ST_T2   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // config
    logic              virt_reg;
    logic [MSHR_W-1:0] mshr_reg;
    logic              wr_hit;
    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            virt_reg <= 1'b0;
            mshr_reg <= MSHR_W'(32);
        end else if (wr_hit) begin
            if (paddr[2] == REG_VIRT) virt_reg <= pwdata[0];
            else                      mshr_reg <= pwdata[MSHR_W-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_VIRT) prdata[0] = virt_reg;
        else                      prdata[MSHR_W-1:0] = mshr_reg;
    end

    // state
    logic [2:0]          state_reg;
    logic [63:0]         addr_reg, ip_reg;
    logic                hit_reg, acc_reg;
    logic [MSHR_W-1:0]   occ_reg;
    logic [63:0]         tick_reg;
    logic [63:0]         la_addr_reg;
    logic [STRIDE_W-1:0] la_stride_reg;
    logic [DEG_W-1:0]    la_rem_reg, degree_reg;
    logic [CNT_W-1:0]    issued_reg, useful_reg;
    logic [WW:0]         way_reg;      // way whose read is being issued
    logic                rd_pend_reg;
    logic                found_reg;
    logic [WW-1:0]       slot_reg;
    logic [63:0]         min_stamp_reg;
    trk_entry_t          hit_ent_reg;
    logic                cmp_lt_reg, cmp_gt_reg;
    logic [79:0]         out_reg;
    logic                out_v_reg;

    logic [SW-1:0] set_idx;
    logic [AW-1:0] rd_addr, wr_addr;
    trk_entry_t    rd_data, wr_data;
    logic          wr_en, clr_done;

    assign set_idx = SW'(ip_reg % SETS);
    assign rd_addr = AW'(set_idx * WAYS + way_reg[WW-1:0]);
    assign wr_addr = AW'(set_idx * WAYS + slot_reg);

    ipsp_tracker #(.DEPTH(DEPTH)) u_trk (
        .aclk, .aresetn, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data, .clr_done
    );

    logic [LINE_W-1:0]   line;
    logic [STRIDE_W-1:0] new_stride;
    assign line       = LINE_W'(addr_reg >> LINE_BITS);
    assign new_stride = {1'b0, line} - {1'b0, hit_ent_reg.line};

    assign wr_en = (state_reg == ST_WR);
    always_comb begin
        wr_data.ip     = ip_reg;
        wr_data.line   = line;
        wr_data.stride = found_reg ? new_stride : '0;
        wr_data.stamp  = tick_reg;
    end

    // shared compare unit: operands chosen by state
    logic [34:0] cmp_a, cmp_b;
    logic        cmp_lt;
    always_comb begin
        cmp_a = {2'b0, useful_reg, 1'b0};
        cmp_b = {3'b0, issued_reg};
        if (state_reg == ST_T1) begin
            cmp_a = {1'b0, issued_reg, 2'b0};
            cmp_b = {1'b0, useful_reg, 2'b0} + {3'b0, useful_reg};
        end
        cmp_lt = cmp_a < cmp_b;
    end

    logic [63:0] next_addr;
    logic        same_pg, offer, fill;
    assign next_addr = la_addr_reg + 64'({{5{la_stride_reg[STRIDE_W-1]}}, la_stride_reg}
                       << LINE_BITS);
    assign same_pg = (next_addr >> PAGE_BITS) == (la_addr_reg >> PAGE_BITS);
    assign offer   = (la_rem_reg != '0) && (virt_reg || same_pg);
    assign fill    = ({1'b0, occ_reg} < ({1'b0, mshr_reg} >> 1));

    logic [DEG_W-1:0] nd;
    always_comb begin
        nd = DEG_W'(2);
        if (issued_reg != '0) begin
            if (cmp_lt_reg)
                nd = (degree_reg > DEG_W'(1)) ? (degree_reg >> 1) : DEG_W'(1);
            else if (cmp_gt_reg)
                nd = ({1'b0, degree_reg} << 1 > (DEG_W+1)'(CAP)) ? DEG_W'(CAP)
                     : DEG_W'(degree_reg << 1);
        end
    end

    assign s_tready = clr_done && (state_reg == ST_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_v_reg     <= 1'b0;
            tick_reg      <= '0;
            la_addr_reg   <= '0;
            la_stride_reg <= '0;
            la_rem_reg    <= '0;
            degree_reg    <= DEG_W'(2);
            issued_reg    <= '0;
            useful_reg    <= '0;
            way_reg       <= '0;
            rd_pend_reg   <= 1'b0;
        end else begin
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        addr_reg <= s_tdata[63:0];
                        ip_reg   <= s_tdata[127:64];
                        hit_reg  <= s_tdata[128];
                        occ_reg  <= s_tdata[137:129];
                        acc_reg  <= s_tdata[138];
                        way_reg  <= '0;
                        rd_pend_reg <= 1'b0;
                        found_reg <= 1'b0;
                        slot_reg <= '0;
                        state_reg <= (s_tuser == FUNC_TICK) ? ST_T0 : ST_RD;
                    end
                end
                ST_RD: begin
                    // issue read for way_reg, evaluate previous read
                    if (rd_pend_reg) begin
                        if (!found_reg) begin
                            if (rd_data.ip == ip_reg) begin
                                found_reg   <= 1'b1;
                                slot_reg    <= WW'(way_reg - 1'b1);
                                hit_ent_reg <= rd_data;
                            end else if (way_reg == (WW+1)'(1)
                                         || rd_data.stamp < min_stamp_reg) begin
                                slot_reg      <= WW'(way_reg - 1'b1);
                                min_stamp_reg <= rd_data.stamp;
                            end
                        end
                    end
                    if (way_reg == (WW+1)'(WAYS)) begin
                        state_reg <= ST_WR;
                    end else begin
                        way_reg     <= way_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                end
                ST_WR: begin
                    if (found_reg && new_stride != '0 && new_stride == hit_ent_reg.stride) begin
                        la_addr_reg   <= 64'(line) << LINE_BITS;
                        la_stride_reg <= new_stride;
                        la_rem_reg    <= degree_reg;
                    end
                    if (issued_reg != '1) issued_reg <= issued_reg + 1'b1;
                    if (!hit_reg && useful_reg != '1) useful_reg <= useful_reg + 1'b1;
                    out_reg   <= {3'b0, degree_reg, 66'b0};
                    state_reg <= ST_OUT;
                end
                ST_T0: begin
                    cmp_lt_reg <= cmp_lt;
                    state_reg  <= ST_T1;
                end
                ST_T1: begin
                    cmp_gt_reg <= cmp_lt;
                    state_reg  <= ST_T2;
                end
                ST_T2: begin
                    degree_reg <= nd;
                    out_reg    <= offer ? {3'b0, nd, fill, next_addr, 1'b1}
                                        : {3'b0, nd, 66'b0};
                    if (la_rem_reg != '0) begin
                        if (offer) begin
                            if (acc_reg) begin
                                la_addr_reg <= next_addr;
                                la_rem_reg  <= la_rem_reg - 1'b1;
                            end
                        end else begin
                            la_addr_reg   <= '0;
                            la_stride_reg <= '0;
                            la_rem_reg    <= '0;
                        end
                    end
                    tick_reg  <= tick_reg + 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    out_v_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

/* sv/ipsp_checker.sv */
// ----------------------------------------------------------------------------
// ipsp_checker
// Port-level checks for the prefetcher.
// ----------------------------------------------------------------------------
module ipsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // no new input while a result waits
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    // degree never zero
    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[76:66] != 11'd0)
        else $error("degree zero");
    // no offer, no address
    a_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[65:1] == 65'd0)
        else $error("address without offer");
    // an accepted input is not followed by ready next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready during work");
endmodule

bind ip_stride_prefetcher_throttled ipsp_checker u_ipsp_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
